FILE: rtl/twalk_pkg.sv
package twalk_pkg;

  // Input item fields
  localparam int REQ_TYPE_W   = 2;
  localparam int ENTRY_ROW_W  = 7;
  localparam int ENTRY_COL_W  = 8;
  localparam int ENTRY_TILE_W = 10;
  localparam int CAM_W        = 18;

  // Result item fields
  localparam int TILE_ROW_W     = 7;
  localparam int TILE_COL_W     = 8;
  localparam int WORLD_X_W      = 16;
  localparam int WORLD_Y_W      = 17;
  localparam int SHEET_LEFT_W   = 16;
  localparam int SHEET_TOP_W    = 18;
  localparam int SHEET_RIGHT_W  = 17;
  localparam int SHEET_BOTTOM_W = 19;

  // Configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 9;

  localparam logic [CFG_INDEX_W-1:0] CFG_TILE_WIDTH         = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TILE_HEIGHT        = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAP_ROW_COUNT      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAP_COLUMN_COUNT   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_SHEET_COLUMN_COUNT = 3'd4;

  // Request codes
  localparam logic [REQ_TYPE_W-1:0] REQ_WRITE  = 2'd0;
  localparam logic [REQ_TYPE_W-1:0] REQ_CAMERA = 2'd1;
  localparam logic [REQ_TYPE_W-1:0] REQ_FETCH  = 2'd2;

  // Internal widths
  localparam int SIZE_W    = 9;                 // tile sizes and sheet columns
  localparam int SIZE_MAX  = 256;
  localparam int ROW_W     = 8;                 // map rows in use
  localparam int COL_W     = 9;                 // map columns in use
  localparam int MH_W      = ROW_W + SIZE_W;    // map height in pixels
  localparam int COL_TW_W  = COL_W + SIZE_W;
  localparam int DIV_W     = 18;                // dividend magnitude
  localparam int QUO_W     = DIV_W + 1;         // signed quotient
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);
  localparam int SL_W      = SIZE_W + SIZE_W;
  localparam int ST_W      = SIZE_W + DIV_W;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [SIZE_W-1:0] TILE_WIDTH_RESET   = 9'd16;
  localparam logic [SIZE_W-1:0] TILE_HEIGHT_RESET  = 9'd16;
  localparam logic [ROW_W-1:0]  MAP_ROWS_RESET     = 8'd128;
  localparam logic [COL_W-1:0]  MAP_COLUMNS_RESET  = 9'd256;
  localparam logic [SIZE_W-1:0] SHEET_COLUMN_RESET = 9'd16;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_CAMERA,
    CMD_FETCH
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                 kind;
    logic [ENTRY_ROW_W-1:0]    entry_row;
    logic [ENTRY_COL_W-1:0]    entry_column;
    logic [ENTRY_TILE_W-1:0]   entry_tile;
    logic signed [CAM_W-1:0]   cam_left;
    logic signed [CAM_W-1:0]   cam_right;
    logic signed [CAM_W-1:0]   cam_top;
    logic signed [CAM_W-1:0]   cam_bottom;
  } cmd_t;

  typedef struct packed {
    logic [SIZE_W-1:0] tile_width;
    logic [SIZE_W-1:0] tile_height;
    logic [ROW_W-1:0]  map_row_count;
    logic [COL_W-1:0]  map_column_count;
    logic [SIZE_W-1:0] sheet_column_count;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic              neg;
    logic [DIV_W-1:0]  mag;
    logic [SIZE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [QUO_W-1:0] quotient;
    logic [SIZE_W-1:0]       remainder;
  } div_rsp_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_CAM_MUL,
    BK_CAM_SUB,
    BK_CAM_DIV,
    BK_CAM_WAIT,
    BK_CAM_FIN,
    BK_TILE_DIV,
    BK_TILE_WAIT,
    BK_TILE_MUL,
    BK_EMIT
  } back_state_t;

  // A size of zero acts as one, anything above 256 (SIZE_MAX) as 256.
  function automatic logic [SIZE_W-1:0] size_eff(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (int'(v) > SIZE_MAX) begin
      r = SIZE_W'(SIZE_MAX);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

FILE: rtl/twalk_ifs.sv
interface twalk_req_if;
  import twalk_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [REQ_TYPE_W-1:0]    req_type;
  logic [ENTRY_ROW_W-1:0]   entry_row;
  logic [ENTRY_COL_W-1:0]   entry_column;
  logic [ENTRY_TILE_W-1:0]  entry_tile;
  logic signed [CAM_W-1:0]  cam_left;
  logic signed [CAM_W-1:0]  cam_right;
  logic signed [CAM_W-1:0]  cam_top;
  logic signed [CAM_W-1:0]  cam_bottom;

  modport source (output valid, req_type, entry_row, entry_column, entry_tile,
                  cam_left, cam_right, cam_top, cam_bottom, input ready);
  modport sink (input valid, req_type, entry_row, entry_column, entry_tile,
                cam_left, cam_right, cam_top, cam_bottom, output ready);
endinterface

interface twalk_rsp_if;
  import twalk_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      has_tile;
  logic                      last_tile;
  logic [TILE_ROW_W-1:0]     tile_row;
  logic [TILE_COL_W-1:0]     tile_column;
  logic [WORLD_X_W-1:0]      world_x;
  logic [WORLD_Y_W-1:0]      world_y;
  logic [SHEET_LEFT_W-1:0]   sheet_left;
  logic [SHEET_TOP_W-1:0]    sheet_top;
  logic [SHEET_RIGHT_W-1:0]  sheet_right;
  logic [SHEET_BOTTOM_W-1:0] sheet_bottom;

  modport source (output valid, has_tile, last_tile, tile_row, tile_column, world_x,
                  world_y, sheet_left, sheet_top, sheet_right, sheet_bottom,
                  input ready);
  modport sink (input valid, has_tile, last_tile, tile_row, tile_column, world_x,
                world_y, sheet_left, sheet_top, sheet_right, sheet_bottom,
                output ready);
endinterface

interface twalk_cfg_if;
  import twalk_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/twalk_front.sv
module twalk_front (
  twalk_req_if.sink        req,
  input  logic             q_full,
  output logic             push,
  output twalk_pkg::cmd_t  cmd
);
  import twalk_pkg::*;

  logic known;

  assign req.ready = !q_full;

  always_comb begin
    cmd.kind         = CMD_FETCH;
    known            = 1'b0;
    cmd.entry_row    = req.entry_row;
    cmd.entry_column = req.entry_column;
    cmd.entry_tile   = req.entry_tile;
    cmd.cam_left     = req.cam_left;
    cmd.cam_right    = req.cam_right;
    cmd.cam_top      = req.cam_top;
    cmd.cam_bottom   = req.cam_bottom;
    unique case (req.req_type)
      REQ_WRITE: begin
        cmd.kind = CMD_WRITE;
        known    = 1'b1;
      end
      REQ_CAMERA: begin
        cmd.kind = CMD_CAMERA;
        known    = 1'b1;
      end
      REQ_FETCH: begin
        cmd.kind = CMD_FETCH;
        known    = 1'b1;
      end
      default: known = 1'b0;
    endcase
  end

  // Unknown request types are taken and dropped here; they never reach the queue.
  assign push = req.valid && !q_full && known;

endmodule

FILE: rtl/twalk_queue.sv
module twalk_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  twalk_pkg::cmd_t wr_cmd,
  input  logic            pop,
  output twalk_pkg::cmd_t head,
  output logic            full,
  output logic            not_empty
);
  import twalk_pkg::*;

  cmd_t               entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

  assign head      = entries[rd_ptr];
  assign full      = (int'(count) == QUEUE_DEPTH);
  assign not_empty = (count != '0);

endmodule

FILE: rtl/twalk_div.sv
module twalk_div (
  input  logic                clk,
  input  logic                rst,
  input  twalk_pkg::div_req_t req,
  output twalk_pkg::div_rsp_t rsp
);
  import twalk_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_W-1:0]     quo;
  logic [SIZE_W-1:0]    rem;
  logic [SIZE_W-1:0]    dsr;
  logic                 neg;
  logic [SIZE_W:0]      trial;
  logic [SIZE_W:0]      diff;
  logic                 ge;
  logic [SIZE_W-1:0]    rem_next;

  // Restoring division, one quotient bit per cycle, most significant first.
  always_comb begin
    trial    = {rem, quo[DIV_W-1]};
    diff     = trial - {1'b0, dsr};
    ge       = (trial >= {1'b0, dsr});
    rem_next = ge ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.mag;
      rem <= '0;
      dsr <= req.divisor;
      neg <= req.neg;
    end else if (busy) begin
      quo <= {quo[DIV_W-2:0], ge};
      rem <= rem_next;
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  assign rsp.remainder = rem;

endmodule

FILE: rtl/twalk_back.sv
module twalk_back #(
  parameter int MAX_MAP_ROWS    = 128,
  parameter int MAX_MAP_COLUMNS = 256,
  parameter int TILE_INDEX_BITS = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  twalk_pkg::cfg_t     cfg,
  input  twalk_pkg::cmd_t     head,
  input  logic                q_not_empty,
  output logic                q_pop,
  output twalk_pkg::div_req_t div_req,
  input  twalk_pkg::div_rsp_t div_rsp,
  twalk_rsp_if.source         rsp
);
  import twalk_pkg::*;

  localparam int STORE_DEPTH = MAX_MAP_ROWS * MAX_MAP_COLUMNS;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CL_W        = QUO_W + 1;

  back_state_t state;
  back_state_t state_next;

  logic [SIZE_W-1:0] tw;
  logic [SIZE_W-1:0] th;
  logic [SIZE_W-1:0] sc;
  logic [ROW_W-1:0]  rows_eff;
  logic [COL_W-1:0]  cols_eff;

  logic [ROW_W-1:0] cur_row;
  logic [ROW_W-1:0] last_row;
  logic [COL_W-1:0] cur_col;
  logic [COL_W-1:0] first_col;
  logic [COL_W-1:0] last_col;
  logic             walk_active;

  logic [TILE_INDEX_BITS-1:0] store [STORE_DEPTH];
  logic [TILE_INDEX_BITS-1:0] rd_data;
  logic [ADDR_W-1:0]          wr_addr;
  logic [ADDR_W-1:0]          rd_addr;
  logic                       store_we;

  logic signed [QUO_W-1:0] cam_num [4];
  logic signed [QUO_W-1:0] cam_quo [4];
  logic [1:0]              cam_cnt;
  logic [DIV_W-1:0]        cam_mag;

  logic [MH_W-1:0]     mh;
  logic [MH_W-1:0]     row_th;
  logic [COL_TW_W-1:0] col_tw;
  logic [DIV_W-1:0]    tile_quo;
  logic [SIZE_W-1:0]   tile_rem;
  logic [SL_W-1:0]     sl;
  logic [ST_W-1:0]     st;
  logic [SL_W-1:0]     sl_plus;
  logic [ST_W-1:0]     st_plus;
  logic [MH_W-1:0]     world_y;
  logic                hit;
  logic                last;
  logic                out_free;
  logic                emit;

  logic signed [CL_W-1:0] c0;
  logic signed [CL_W-1:0] c1;
  logic signed [CL_W-1:0] r0;
  logic signed [CL_W-1:0] r1;
  logic signed [CL_W-1:0] cols_s;
  logic signed [CL_W-1:0] rows_s;
  logic                   window_empty;

  assign tw       = size_eff(cfg.tile_width);
  assign th       = size_eff(cfg.tile_height);
  assign sc       = size_eff(cfg.sheet_column_count);
  assign rows_eff = (int'(cfg.map_row_count) > MAX_MAP_ROWS) ?
                    ROW_W'(MAX_MAP_ROWS) : cfg.map_row_count;
  assign cols_eff = (int'(cfg.map_column_count) > MAX_MAP_COLUMNS) ?
                    COL_W'(MAX_MAP_COLUMNS) : cfg.map_column_count;

  assign wr_addr = ADDR_W'(int'(head.entry_row) * MAX_MAP_COLUMNS + int'(head.entry_column));
  assign rd_addr = ADDR_W'(int'(cur_row) * MAX_MAP_COLUMNS + int'(cur_col));

  // The cursor only moves on an emitted tile or when a camera request finishes, so the read port can run every cycle.
  always_ff @(posedge clk) begin
    if (store_we) begin
      store[wr_addr] <= TILE_INDEX_BITS'(head.entry_tile);
    end
    rd_data <= store[rd_addr];
  end

  assign cam_mag  = DIV_W'($unsigned(cam_num[0][QUO_W-1] ? -cam_num[0] : cam_num[0]));
  assign out_free = !rsp.valid || rsp.ready;
  assign last     = (cur_row == last_row) && (cur_col == last_col);
  assign sl_plus  = sl + SL_W'(tw);
  assign st_plus  = st + ST_W'(th);

  // Window clamp on the four quotients: left, right, top and bottom.
  always_comb begin
    cols_s = $signed(CL_W'(cols_eff));
    rows_s = $signed(CL_W'(rows_eff));
    c0     = (cam_quo[0] < 0) ? '0 : CL_W'(cam_quo[0]);
    r0     = (cam_quo[2] < 0) ? '0 : CL_W'(cam_quo[2]);
    c1     = (CL_W'(cam_quo[1]) >= cols_s) ? cols_s - CL_W'(1) : CL_W'(cam_quo[1]);
    r1     = (CL_W'(cam_quo[3]) >= rows_s) ? rows_s - CL_W'(1) : CL_W'(cam_quo[3]);
    window_empty = (c0 > c1) || (r0 > r1) || (c0 >= cols_s) || (r0 >= rows_s) ||
                   (c1 < 0) || (r1 < 0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    store_we   = 1'b0;
    emit       = 1'b0;
    div_req    = '0;
    unique case (state)
      BK_IDLE: begin
        if (q_not_empty) begin
          q_pop = 1'b1;
          unique case (head.kind)
            CMD_WRITE: begin
              store_we = (int'(head.entry_row) < MAX_MAP_ROWS) &&
                         (int'(head.entry_column) < MAX_MAP_COLUMNS);
            end
            CMD_CAMERA: state_next = BK_CAM_MUL;
            CMD_FETCH:  state_next = walk_active ? BK_TILE_DIV : BK_EMIT;
            default:    state_next = BK_IDLE;
          endcase
        end
      end
      BK_CAM_MUL: state_next = BK_CAM_SUB;
      BK_CAM_SUB: state_next = BK_CAM_DIV;
      BK_CAM_DIV: begin
        div_req.start = 1'b1;
        div_req.neg   = cam_num[0][QUO_W-1];
        div_req.mag   = cam_mag;
        // Left and right divide by the tile width, top and bottom by the tile height.
        div_req.divisor = cam_cnt[1] ? th : tw;
        state_next      = BK_CAM_WAIT;
      end
      BK_CAM_WAIT: begin
        if (div_rsp.done) begin
          state_next = (cam_cnt == 2'd3) ? BK_CAM_FIN : BK_CAM_DIV;
        end
      end
      BK_CAM_FIN: state_next = BK_IDLE;
      BK_TILE_DIV: begin
        div_req.start   = 1'b1;
        div_req.neg     = 1'b0;
        div_req.mag     = DIV_W'(rd_data);
        div_req.divisor = sc;
        state_next      = BK_TILE_WAIT;
      end
      BK_TILE_WAIT: begin
        if (div_rsp.done) begin
          state_next = BK_TILE_MUL;
        end
      end
      BK_TILE_MUL: state_next = BK_EMIT;
      BK_EMIT: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        hit        <= walk_active;
        cam_cnt    <= '0;
        cam_num[0] <= QUO_W'(head.cam_left);
        cam_num[1] <= QUO_W'(head.cam_right);
        cam_num[2] <= QUO_W'(head.cam_top);
        cam_num[3] <= QUO_W'(head.cam_bottom);
      end
      BK_CAM_MUL: mh <= rows_eff * th;
      BK_CAM_SUB: begin
        cam_num[2] <= $signed(QUO_W'(mh)) - cam_num[2];
        cam_num[3] <= $signed(QUO_W'(mh)) - cam_num[3];
      end
      BK_CAM_WAIT: begin
        if (div_rsp.done) begin
          cam_cnt    <= cam_cnt + 1'b1;
          cam_num[0] <= cam_num[1];
          cam_num[1] <= cam_num[2];
          cam_num[2] <= cam_num[3];
          cam_quo[0] <= cam_quo[1];
          cam_quo[1] <= cam_quo[2];
          cam_quo[2] <= cam_quo[3];
          cam_quo[3] <= div_rsp.quotient;
        end
      end
      BK_TILE_DIV: begin
        col_tw <= cur_col * tw;
        row_th <= cur_row * th;
        mh     <= rows_eff * th;
      end
      BK_TILE_WAIT: begin
        if (div_rsp.done) begin
          tile_quo <= div_rsp.quotient[DIV_W-1:0];
          tile_rem <= div_rsp.remainder;
        end
      end
      BK_TILE_MUL: begin
        sl      <= tw * tile_rem;
        st      <= th * tile_quo;
        world_y <= mh - row_th;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row     <= '0;
      cur_col     <= '0;
      first_col   <= '0;
      last_col    <= '0;
      last_row    <= '0;
      walk_active <= 1'b0;
    end else if (state == BK_CAM_FIN) begin
      if (window_empty) begin
        walk_active <= 1'b0;
      end else begin
        first_col   <= c0[COL_W-1:0];
        last_col    <= c1[COL_W-1:0];
        last_row    <= r1[ROW_W-1:0];
        cur_row     <= r0[ROW_W-1:0];
        cur_col     <= c0[COL_W-1:0];
        walk_active <= 1'b1;
      end
    end else if (emit && hit) begin
      if (cur_col >= last_col) begin
        if (cur_row >= last_row) begin
          walk_active <= 1'b0;
        end else begin
          cur_row <= cur_row + 1'b1;
          cur_col <= first_col;
        end
      end else begin
        cur_col <= cur_col + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (emit) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  // A finished walk reports an all-zero result.
  always_ff @(posedge clk) begin
    if (emit) begin
      rsp.has_tile     <= hit;
      rsp.last_tile    <= hit && last;
      rsp.tile_row     <= hit ? cur_row[TILE_ROW_W-1:0] : '0;
      rsp.tile_column  <= hit ? cur_col[TILE_COL_W-1:0] : '0;
      rsp.world_x      <= hit ? col_tw[WORLD_X_W-1:0] : '0;
      rsp.world_y      <= hit ? world_y[WORLD_Y_W-1:0] : '0;
      rsp.sheet_left   <= hit ? sl[SHEET_LEFT_W-1:0] : '0;
      rsp.sheet_top    <= hit ? st[SHEET_TOP_W-1:0] : '0;
      rsp.sheet_right  <= hit ? sl_plus[SHEET_RIGHT_W-1:0] : '0;
      rsp.sheet_bottom <= hit ? st_plus[SHEET_BOTTOM_W-1:0] : '0;
    end
  end

endmodule

FILE: rtl/tile_map_visible_tile_walker.sv
// Tile map walker: write requests fill the tile map, a camera request clamps a world
// window (y up) to the map, and each fetch request returns the next visible tile in
// row-major order with its world position and tile-sheet rectangle, or has_tile 0 once
// the walk is over. Requests pass through a two-entry queue, so the request side can
// go on taking requests, until the queue is full, while a result waits on the response side.
// Fetches within a walk and camera requests both wait on the shared radix-2 divider,
// which runs 18 steps per division (one for the tile index over the sheet width, four
// for the camera edges); a fetch after the walk is over skips the divider. The map
// memory comes up undefined and has no clearing pass: read only entries that have
// been written. Configuration writes are taken at any time but must only be made while
// the block is idle.
module tile_map_visible_tile_walker #(
  parameter int MAX_MAP_ROWS    = 128,
  parameter int MAX_MAP_COLUMNS = 256,
  parameter int TILE_INDEX_BITS = 10
) (
  input logic         clk,
  input logic         rst,
  twalk_req_if.sink   req,
  twalk_rsp_if.source rsp,
  twalk_cfg_if.sink   cfg
);
  import twalk_pkg::*;

  cfg_t     cfg_regs;
  cmd_t     q_wr_cmd;
  cmd_t     q_head;
  logic     q_push;
  logic     q_pop;
  logic     q_full;
  logic     q_not_empty;
  div_req_t div_req;
  div_rsp_t div_rsp;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.tile_width         <= TILE_WIDTH_RESET;
      cfg_regs.tile_height        <= TILE_HEIGHT_RESET;
      cfg_regs.map_row_count      <= MAP_ROWS_RESET;
      cfg_regs.map_column_count   <= MAP_COLUMNS_RESET;
      cfg_regs.sheet_column_count <= SHEET_COLUMN_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_TILE_WIDTH:         cfg_regs.tile_width         <= cfg.data;
        CFG_TILE_HEIGHT:        cfg_regs.tile_height        <= cfg.data;
        CFG_MAP_ROW_COUNT:      cfg_regs.map_row_count      <= cfg.data[ROW_W-1:0];
        CFG_MAP_COLUMN_COUNT:   cfg_regs.map_column_count   <= cfg.data;
        CFG_SHEET_COLUMN_COUNT: cfg_regs.sheet_column_count <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  twalk_front u_front (
    .req    (req),
    .q_full (q_full),
    .push   (q_push),
    .cmd    (q_wr_cmd)
  );

  twalk_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .wr_cmd    (q_wr_cmd),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  twalk_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  twalk_back #(
    .MAX_MAP_ROWS    (MAX_MAP_ROWS),
    .MAX_MAP_COLUMNS (MAX_MAP_COLUMNS),
    .TILE_INDEX_BITS (TILE_INDEX_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg_regs),
    .head        (q_head),
    .q_not_empty (q_not_empty),
    .q_pop       (q_pop),
    .div_req     (div_req),
    .div_rsp     (div_rsp),
    .rsp         (rsp)
  );

  a_push_room: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("request queue written while full");

  a_pop_data: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_not_empty)
    else $error("request queue read while empty");

  a_done_zero: assert property (@(posedge clk) disable iff (rst)
      rsp.valid && !rsp.has_tile |->
        (!rsp.last_tile && rsp.world_x == '0 && rsp.sheet_right == '0))
    else $error("finished-walk result carries tile data");

  a_last_has: assert property (@(posedge clk) disable iff (rst)
      rsp.valid && rsp.last_tile |-> rsp.has_tile)
    else $error("last tile flagged without a tile");

endmodule
